// ===== design/partial_l4_checksum_fixup_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the partial L4 checksum fixup block
// Concurrent checks on the rising edge of clk; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef PARTIAL_L4_CHECKSUM_FIXUP_DEFINES_SVH
`define PARTIAL_L4_CHECKSUM_FIXUP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that is switched off while reset is high.
`define PL4C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also holds while reset is high.
`define PL4C_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PL4C_ASSERT(lbl, prop, msg)
`define PL4C_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/pl4c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl4c_pkg
// Constants, types and ones' complement helpers for the L4 checksum fixup.
// ----------------------------------------------------------------------------
package pl4c_pkg;

  localparam int MAX_FRAME_BYTES = 2048;
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  // The compare width covers both the frame position and a 16-bit length plus 14.
  localparam int CMP_W = (POS_W > 17) ? POS_W : 17;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION4    = 4'd4;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [6:0]  ETH_HDR_BYTES  = 7'd14;
  localparam logic [5:0]  MIN_IP_HDR     = 6'd20;
  localparam logic [6:0]  MIN_FRAME      = 7'd34;
  localparam logic [4:0]  TCP_CSUM_OFF   = 5'd16;
  localparam logic [4:0]  UDP_CSUM_OFF   = 5'd6;

  // Frame offsets of the header bytes that are captured.
  localparam logic [POS_W-1:0] POS_ETYPE_HI = POS_W'(12);
  localparam logic [POS_W-1:0] POS_ETYPE_LO = POS_W'(13);
  localparam logic [POS_W-1:0] POS_IP_VHL   = POS_W'(14);
  localparam logic [POS_W-1:0] POS_TLEN_HI  = POS_W'(16);
  localparam logic [POS_W-1:0] POS_TLEN_LO  = POS_W'(17);
  localparam logic [POS_W-1:0] POS_FRAG_HI  = POS_W'(20);
  localparam logic [POS_W-1:0] POS_FRAG_LO  = POS_W'(21);
  localparam logic [POS_W-1:0] POS_PROTO    = POS_W'(23);
  localparam logic [POS_W-1:0] POS_ADDR_FIRST = POS_W'(26);
  localparam logic [POS_W-1:0] POS_ADDR_LAST  = POS_W'(33);

  // Everything the result stage needs about one finished frame.
  typedef struct packed {
    logic             fix_enable;
    logic             length_overflow;
    logic [POS_W-1:0] frame_len;
    logic [15:0]      ether_type;
    logic [3:0]       ip_version;
    logic [5:0]       header_bytes;
    logic [15:0]      total_length;
    logic             fragment_nonzero;
    logic [7:0]       protocol_number;
    logic [15:0]      address_sum;
    logic [15:0]      stored_checksum;
    logic [15:0]      segment_sum;
  } frame_summary_t;

  // Ones' complement add of two 16-bit values; one end-around fold is enough.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Folds a plain sum of a few 16-bit terms into its ones' complement value.
  function automatic logic [15:0] oc_fold(input logic [18:0] s);
    logic [16:0] t;
    t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

// ===== design/partial_l4_checksum_fixup.sv =====
`timescale 1ns / 1ps
`include "partial_l4_checksum_fixup_defines.svh"
// ----------------------------------------------------------------------------
// partial_l4_checksum_fixup
// Completes a partial TCP/UDP checksum of an IPv4 Ethernet frame.
// ----------------------------------------------------------------------------
//   channel   direction  payload
//   cfg       in         cfg_data = fix_enable
//   s_*       in         tdata[7:0] = frame_byte, tlast = last_byte
//   m_*       out        tdata = patch_valid, checksum_offset, new_checksum
//
// One frame byte is taken every cycle while s_tready is high; the parse and
// running sums are updated in the cycle the byte is accepted. The last byte
// of a frame moves a summary into a finish register; from there the verdict
// moves on into the result register once that register is free.
// Reset clears the parse state and sets fix_enable to 1. s_tready drops only
// while the finish register is full and cannot move into a stalled result
// register.
// ----------------------------------------------------------------------------
module partial_l4_checksum_fixup
  import pl4c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,      // fix_enable
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // [7:0] frame_byte
  input  logic        s_tlast,       // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata        // [0] patch_valid, [7:1] checksum_offset,
                                     // [23:8] new_checksum
);

  logic fix_enable;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             length_overflow, length_overflow_next;
  logic [15:0]      ether_type, ether_type_next;
  logic [3:0]       ip_version, ip_version_next;
  logic [5:0]       header_bytes, header_bytes_next;
  logic [15:0]      total_length, total_length_next;
  logic             fragment_nonzero, fragment_nonzero_next;
  logic [7:0]       protocol_number, protocol_number_next;
  logic [15:0]      address_sum, address_sum_next;
  logic [15:0]      stored_checksum, stored_checksum_next;
  logic [15:0]      segment_sum, segment_sum_next;

  logic [CMP_W-1:0] pos_w, seg_start, seg_index;
  logic [15:0]      ip_payload_len;
  logic             in_segment;
  logic [4:0]       field_off;
  logic [7:0]       seg_byte;

  frame_summary_t fin;
  logic           fin_valid;
  logic           fin_advance;
  logic           in_accept;

  logic             out_valid;
  logic             out_patch;
  logic [6:0]       out_offset;
  logic [15:0]      out_checksum;

  logic             f_tcp, f_udp;
  logic [4:0]       f_off;
  logic [15:0]      f_trlen;
  logic [CMP_W-1:0] f_len_w;
  logic             f_checks_ok;
  logic [18:0]      pseudo_raw, total_raw;
  logic [15:0]      pseudo, fixed_sum;
  logic             f_patch;
  logic [6:0]       f_offset;

  assign cfg_ready   = 1'b1;
  assign s_tready    = !fin_valid || fin_advance;
  assign in_accept   = s_tvalid && s_tready;
  assign fin_advance = fin_valid && (!out_valid || m_tready);

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_checksum, out_offset, out_patch};

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_enable <= 1'b1;
    end else if (cfg_valid) begin
      fix_enable <= cfg_data;
    end
  end

  // Header capture and running sums for the byte on the input.
  always_comb begin
    ether_type_next       = ether_type;
    ip_version_next       = ip_version;
    header_bytes_next     = header_bytes;
    total_length_next     = total_length;
    fragment_nonzero_next = fragment_nonzero;
    protocol_number_next  = protocol_number;
    address_sum_next      = address_sum;
    stored_checksum_next  = stored_checksum;
    segment_sum_next      = segment_sum;
    byte_position_next    = byte_position;
    length_overflow_next  = length_overflow;

    unique case (byte_position)
      POS_ETYPE_HI: ether_type_next = {s_tdata, ether_type[7:0]};
      POS_ETYPE_LO: ether_type_next = {ether_type[15:8], s_tdata};
      POS_IP_VHL: begin
        ip_version_next   = s_tdata[7:4];
        header_bytes_next = {s_tdata[3:0], 2'b00};
      end
      POS_TLEN_HI:  total_length_next = {s_tdata, total_length[7:0]};
      POS_TLEN_LO:  total_length_next = {total_length[15:8], s_tdata};
      POS_FRAG_HI:  fragment_nonzero_next = (s_tdata[5:0] != 6'd0);
      POS_FRAG_LO: begin
        if (s_tdata != 8'd0) begin
          fragment_nonzero_next = 1'b1;
        end
      end
      POS_PROTO:    protocol_number_next = s_tdata;
      default: ;
    endcase

    if (byte_position >= POS_ADDR_FIRST && byte_position <= POS_ADDR_LAST) begin
      address_sum_next = oc_add(address_sum,
                                byte_position[0] ? {8'h00, s_tdata} : {s_tdata, 8'h00});
    end

    // The segment window uses the header fields as updated by this same byte.
    pos_w          = CMP_W'(byte_position);
    seg_start      = CMP_W'(ETH_HDR_BYTES) + CMP_W'(header_bytes_next);
    seg_index      = pos_w - seg_start;
    ip_payload_len = total_length_next - {10'd0, header_bytes_next};
    in_segment     = (pos_w >= seg_start) && (total_length_next >= {10'd0, header_bytes_next})
                     && (seg_index < CMP_W'(ip_payload_len));
    field_off      = (protocol_number_next == PROTO_TCP) ? TCP_CSUM_OFF : UDP_CSUM_OFF;
    seg_byte       = s_tdata;

    if (in_segment) begin
      // The checksum bytes are captured and summed as zero.
      if (seg_index == CMP_W'(field_off)) begin
        stored_checksum_next = {s_tdata, stored_checksum[7:0]};
        seg_byte             = 8'h00;
      end else if (seg_index == CMP_W'(field_off) + CMP_W'(1)) begin
        stored_checksum_next = {stored_checksum[15:8], s_tdata};
        seg_byte             = 8'h00;
      end
      segment_sum_next = oc_add(segment_sum,
                                seg_index[0] ? {8'h00, seg_byte} : {seg_byte, 8'h00});
    end

    if (byte_position >= MAX_POS) begin
      length_overflow_next = 1'b1;
    end else begin
      byte_position_next = byte_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_accept && s_tlast)) begin
      byte_position    <= '0;
      length_overflow  <= 1'b0;
      ether_type       <= '0;
      ip_version       <= '0;
      header_bytes     <= '0;
      total_length     <= '0;
      fragment_nonzero <= 1'b0;
      protocol_number  <= '0;
      address_sum      <= '0;
      stored_checksum  <= '0;
      segment_sum      <= '0;
    end else if (in_accept) begin
      byte_position    <= byte_position_next;
      length_overflow  <= length_overflow_next;
      ether_type       <= ether_type_next;
      ip_version       <= ip_version_next;
      header_bytes     <= header_bytes_next;
      total_length     <= total_length_next;
      fragment_nonzero <= fragment_nonzero_next;
      protocol_number  <= protocol_number_next;
      address_sum      <= address_sum_next;
      stored_checksum  <= stored_checksum_next;
      segment_sum      <= segment_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (in_accept && s_tlast) begin
      fin_valid <= 1'b1;
    end else if (fin_advance) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && s_tlast) begin
      fin.fix_enable       <= fix_enable;
      fin.length_overflow  <= length_overflow_next;
      fin.frame_len        <= byte_position_next;
      fin.ether_type       <= ether_type_next;
      fin.ip_version       <= ip_version_next;
      fin.header_bytes     <= header_bytes_next;
      fin.total_length     <= total_length_next;
      fin.fragment_nonzero <= fragment_nonzero_next;
      fin.protocol_number  <= protocol_number_next;
      fin.address_sum      <= address_sum_next;
      fin.stored_checksum  <= stored_checksum_next;
      fin.segment_sum      <= segment_sum_next;
    end
  end

  // Verdict for a finished frame.
  always_comb begin
    f_tcp   = (fin.protocol_number == PROTO_TCP);
    f_udp   = (fin.protocol_number == PROTO_UDP);
    f_off   = f_tcp ? TCP_CSUM_OFF : UDP_CSUM_OFF;
    f_trlen = fin.total_length - {10'd0, fin.header_bytes};
    f_len_w = CMP_W'(fin.frame_len);

    f_checks_ok = fin.fix_enable && !fin.length_overflow
                  && (f_len_w >= CMP_W'(MIN_FRAME))
                  && (fin.ether_type == ETHERTYPE_IPV4)
                  && (fin.ip_version == IP_VERSION4)
                  && (fin.header_bytes >= MIN_IP_HDR)
                  && (fin.total_length >= {10'd0, fin.header_bytes})
                  && (CMP_W'(fin.total_length) + CMP_W'(ETH_HDR_BYTES) <= f_len_w)
                  && !fin.fragment_nonzero
                  && (f_tcp || f_udp)
                  && (f_trlen >= {11'd0, f_off} + 16'd2);

    // A single fold of the plain sum equals the chain of end-around adds.
    pseudo_raw = {3'd0, fin.address_sum} + {11'd0, fin.protocol_number} + {3'd0, f_trlen};
    total_raw  = pseudo_raw + {3'd0, fin.segment_sum};
    pseudo     = oc_fold(pseudo_raw);
    fixed_sum  = ~oc_fold(total_raw);
    if (f_udp && fixed_sum == 16'h0000) begin
      fixed_sum = 16'hffff;
    end

    f_patch  = f_checks_ok
               && ((fin.stored_checksum == pseudo) || (fin.stored_checksum == ~pseudo));
    f_offset = ETH_HDR_BYTES + {1'b0, fin.header_bytes} + {2'b00, f_off};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_advance) begin
      out_patch    <= f_patch;
      out_offset   <= f_patch ? f_offset : 7'd0;
      out_checksum <= f_patch ? fixed_sum : 16'd0;
    end
  end

  `PL4C_ASSERT(a_no_patch_zero_fields, m_tvalid && !m_tdata[0] |-> m_tdata[23:1] == 23'd0, "result without patch carries nonzero fields")
  `PL4C_ASSERT(a_last_closes_frame, s_tvalid && s_tready && s_tlast |=> fin_valid && byte_position == '0, "last byte did not close the frame")
  `PL4C_ASSERT_ALWAYS(a_overflow_saturates, length_overflow |-> byte_position == MAX_POS, "overflow flagged below the position limit")

endmodule

// ===== tb/tb_partial_l4_checksum_fixup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_partial_l4_checksum_fixup
// Sends Ethernet frames one byte per request and checks every patch verdict
// against a byte-level checksum predictor kept inside the bench. Directed
// frames cover the special cases; then random frames run, most of them
// well-formed, under random idling on both streams and both settings of
// fix_enable.
// ----------------------------------------------------------------------------
module tb_partial_l4_checksum_fixup;
  import pl4c_pkg::*;

  localparam logic [7:0] PROTO_ICMP = 8'd1;

  typedef enum {CS_PSEUDO, CS_INVERTED, CS_WRONG} stored_csum_mode_t;

  // Verdict for one frame, packed in the order of m_tdata.
  typedef struct packed {
    logic [15:0] csum;
    logic [6:0]  offset;
    logic        patch;
  } patch_result_t;

  typedef struct {
    logic [15:0]       ether_type;
    logic [3:0]        version;
    logic [3:0]        ihl;
    logic [7:0]        proto;
    int                seg_len;
    int                tl_delta;
    int                pad;
    int                cut;
    logic [7:0]        frag_hi;
    logic [7:0]        frag_lo;
    stored_csum_mode_t csum_mode;
    bit                zero_sum;
  } frame_recipe_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  always #10 clk = ~clk;

  partial_l4_checksum_fixup dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Predictor state for the frame in flight.
  bit               fix_en_model    = 1'b1;
  logic [POS_W-1:0] frame_pos       = '0;
  bit               pos_saturated   = 1'b0;
  logic [15:0]      seen_ether_type = '0;
  logic [3:0]       seen_version    = '0;
  logic [5:0]       seen_hdr_bytes  = '0;
  logic [15:0]      seen_total_len  = '0;
  bit               seen_fragment   = 1'b0;
  logic [7:0]       seen_proto      = '0;
  logic [15:0]      addr_sum        = '0;
  logic [15:0]      stored_csum     = '0;
  logic [15:0]      seg_sum         = '0;

  patch_result_t patch_expect_q[$];
  logic [7:0]    frame_q[$];
  int            mismatch_count = 0;
  int            bytes_sent     = 0;
  int            frames_sent    = 0;
  int            src_max_gap    = 3;
  int            sink_max_gap   = 3;

  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    int unsigned s;
    s = a + b;
    while (s > 32'hffff) s = (s & 32'hffff) + (s >> 16);
    return s[15:0];
  endfunction

  // Advances the parse by one accepted byte; on the last byte it queues the
  // expected verdict and starts a fresh frame.
  function automatic void track_frame_byte(logic [7:0] b, logic is_last);
    int unsigned   pos;
    int unsigned   seg_first;
    int unsigned   idx;
    int unsigned   off;
    int unsigned   trlen;
    int unsigned   frame_len;
    logic [7:0]    v;
    logic [15:0]   pseudo;
    logic [15:0]   fixed;
    bit            ok;
    patch_result_t res;
    pos = frame_pos;
    case (frame_pos)
      POS_ETYPE_HI: seen_ether_type[15:8] = b;
      POS_ETYPE_LO: seen_ether_type[7:0] = b;
      POS_IP_VHL: begin
        seen_version   = b[7:4];
        seen_hdr_bytes = {b[3:0], 2'b00};
      end
      POS_TLEN_HI:  seen_total_len[15:8] = b;
      POS_TLEN_LO:  seen_total_len[7:0] = b;
      POS_FRAG_HI:  seen_fragment = (b[5:0] != 6'd0);
      POS_FRAG_LO:  if (b != 8'd0) seen_fragment = 1'b1;
      POS_PROTO:    seen_proto = b;
      default: ;
    endcase
    if (frame_pos >= POS_ADDR_FIRST && frame_pos <= POS_ADDR_LAST)
      addr_sum = ones_add(addr_sum, frame_pos[0] ? {8'h00, b} : {b, 8'h00});

    // The header fields may still change under the segment window when the
    // header length is too small; the window follows them byte by byte.
    seg_first = ETH_HDR_BYTES + seen_hdr_bytes;
    off = (seen_proto == PROTO_TCP) ? TCP_CSUM_OFF : UDP_CSUM_OFF;
    if (pos >= seg_first && seen_total_len >= seen_hdr_bytes &&
        pos - seg_first < seen_total_len - seen_hdr_bytes) begin
      idx = pos - seg_first;
      v = b;
      if (idx == off) begin
        stored_csum[15:8] = b;
        v = 8'h00;
      end else if (idx == off + 1) begin
        stored_csum[7:0] = b;
        v = 8'h00;
      end
      seg_sum = ones_add(seg_sum, idx[0] ? {8'h00, v} : {v, 8'h00});
    end

    if (frame_pos >= MAX_POS) pos_saturated = 1'b1;
    else frame_pos = frame_pos + 1'b1;

    if (!is_last) return;

    frame_len = frame_pos;
    trlen = seen_total_len - seen_hdr_bytes;
    ok = fix_en_model && !pos_saturated && frame_len >= MIN_FRAME &&
         seen_ether_type == ETHERTYPE_IPV4 && seen_version == IP_VERSION4 &&
         seen_hdr_bytes >= MIN_IP_HDR && seen_total_len >= seen_hdr_bytes &&
         seen_total_len + ETH_HDR_BYTES <= frame_len && !seen_fragment &&
         (seen_proto == PROTO_TCP || seen_proto == PROTO_UDP);
    if (ok && trlen < off + 2) ok = 1'b0;
    res = '0;
    if (ok) begin
      pseudo = ones_add(ones_add(addr_sum, {8'h00, seen_proto}), trlen[15:0]);
      if (stored_csum == pseudo || stored_csum == ~pseudo) begin
        fixed = ~ones_add(pseudo, seg_sum);
        if (seen_proto == PROTO_UDP && fixed == 16'h0000) fixed = 16'hffff;
        res.patch  = 1'b1;
        res.offset = 7'(ETH_HDR_BYTES + seen_hdr_bytes + off);
        res.csum   = fixed;
      end
    end
    patch_expect_q.push_back(res);

    frame_pos       = '0;
    pos_saturated   = 1'b0;
    seen_ether_type = '0;
    seen_version    = '0;
    seen_hdr_bytes  = '0;
    seen_total_len  = '0;
    seen_fragment   = 1'b0;
    seen_proto      = '0;
    addr_sum        = '0;
    stored_csum     = '0;
    seg_sum         = '0;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic send_byte(logic [7:0] b, logic is_last);
    int gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    track_frame_byte(b, is_last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  task automatic send_noise(int len, int fill);
    frame_q.delete();
    repeat (len) frame_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    send_frame();
  endtask

  // Builds a frame from the recipe. The transport checksum field is loaded
  // with the pseudo-header sum (or its complement) as a NIC driver would, or with a copy with one bit flipped.
  task automatic send_recipe(frame_recipe_t r);
    int          hb_emit;
    int          seg_first;
    int          off;
    int          tl_int;
    logic [15:0] tl;
    logic [15:0] pseudo;
    logic [15:0] partial;
    logic [15:0] w;
    logic [15:0] stored;
    frame_q.delete();
    repeat (12) frame_q.push_back(8'($urandom));
    frame_q.push_back(r.ether_type[15:8]);
    frame_q.push_back(r.ether_type[7:0]);
    frame_q.push_back({r.version, r.ihl});
    frame_q.push_back(8'($urandom));
    hb_emit = (r.ihl >= 5) ? r.ihl * 4 : 20;
    tl_int = r.ihl * 4 + r.seg_len + r.tl_delta;
    if (tl_int < 0) tl_int = 0;
    if (tl_int > 65535) tl_int = 65535;
    tl = 16'(tl_int);
    frame_q.push_back(tl[15:8]);
    frame_q.push_back(tl[7:0]);
    repeat (2) frame_q.push_back(8'($urandom));
    frame_q.push_back(r.frag_hi);
    frame_q.push_back(r.frag_lo);
    frame_q.push_back(8'($urandom));
    frame_q.push_back(r.proto);
    repeat (2) frame_q.push_back(8'($urandom));
    repeat (8 + hb_emit - 20) frame_q.push_back(8'($urandom));
    seg_first = frame_q.size();
    repeat (r.seg_len) frame_q.push_back(8'($urandom));

    off = (r.proto == PROTO_TCP) ? TCP_CSUM_OFF : UDP_CSUM_OFF;
    if (r.seg_len >= off + 2) begin
      pseudo = 16'h0000;
      for (int i = 26; i < 34; i += 2) pseudo = ones_add(pseudo, {frame_q[i], frame_q[i+1]});
      pseudo = ones_add(ones_add(pseudo, {8'h00, r.proto}), 16'(r.seg_len));
      frame_q[seg_first+off]   = 8'h00;
      frame_q[seg_first+off+1] = 8'h00;
      // Tune the word after the checksum so the folded sum comes out as all
      // ones, which makes the corrected checksum zero (sent as all ones for UDP).
      if (r.zero_sum && r.seg_len >= off + 4) begin
        frame_q[seg_first+off+2] = 8'h00;
        frame_q[seg_first+off+3] = 8'h00;
        partial = pseudo;
        for (int i = 0; i < r.seg_len; i += 2)
          partial = ones_add(partial, {frame_q[seg_first+i],
                                       (i + 1 < r.seg_len) ? frame_q[seg_first+i+1] : 8'h00});
        w = ~partial;
        frame_q[seg_first+off+2] = w[15:8];
        frame_q[seg_first+off+3] = w[7:0];
      end
      case (r.csum_mode)
        CS_PSEUDO:   stored = pseudo;
        CS_INVERTED: stored = ~pseudo;
        default:     stored = pseudo ^ (16'h0001 << $urandom_range(0, 15));
      endcase
      frame_q[seg_first+off]   = stored[15:8];
      frame_q[seg_first+off+1] = stored[7:0];
    end
    repeat (r.pad) frame_q.push_back(8'($urandom));
    repeat (r.cut) if (frame_q.size() > 1) void'(frame_q.pop_back());
    send_frame();
  endtask

  function automatic frame_recipe_t base_recipe(logic [7:0] proto, int seg_len);
    frame_recipe_t r;
    r.ether_type = ETHERTYPE_IPV4;
    r.version    = IP_VERSION4;
    r.ihl        = 4'd5;
    r.proto      = proto;
    r.seg_len    = seg_len;
    r.tl_delta   = 0;
    r.pad        = 0;
    r.cut        = 0;
    r.frag_hi    = 8'h00;
    r.frag_lo    = 8'h00;
    r.csum_mode  = CS_PSEUDO;
    r.zero_sum   = 1'b0;
    return r;
  endfunction

  // Mostly well-formed frames with random content; a minority breaks one or
  // more header checks.
  function automatic frame_recipe_t random_recipe();
    frame_recipe_t r;
    int            off;
    int            k;
    r = base_recipe(($urandom_range(0, 1) == 0) ? PROTO_TCP : PROTO_UDP, 0);
    off = (r.proto == PROTO_TCP) ? TCP_CSUM_OFF : UDP_CSUM_OFF;
    r.seg_len = off + 2 + $urandom_range(0, 24);
    if ($urandom_range(0, 99) < 8) r.seg_len = $urandom_range(0, off + 1);
    k = $urandom_range(0, 99);
    if (k < 65) r.ihl = 4'd5;
    else if (k < 92) r.ihl = 4'($urandom_range(6, 15));
    else r.ihl = 4'($urandom_range(0, 4));
    r.frag_hi = {2'($urandom), 6'd0};
    if ($urandom_range(0, 99) < 6) r.frag_hi = 8'($urandom);
    if ($urandom_range(0, 99) < 6) r.frag_lo = 8'($urandom);
    if ($urandom_range(0, 99) < 5) r.ether_type = 16'($urandom);
    if ($urandom_range(0, 99) < 5) r.version = 4'($urandom);
    if ($urandom_range(0, 99) < 6) r.proto = 8'($urandom);
    k = $urandom_range(0, 99);
    if (k < 8) r.tl_delta = $urandom_range(0, 12) - 6;
    else if (k < 10) r.tl_delta = 65535;
    if ($urandom_range(0, 99) < 25) r.pad = $urandom_range(1, 12);
    if ($urandom_range(0, 99) < 8) r.cut = $urandom_range(1, 8);
    k = $urandom_range(0, 99);
    if (k < 46) r.csum_mode = CS_PSEUDO;
    else if (k < 92) r.csum_mode = CS_INVERTED;
    else r.csum_mode = CS_WRONG;
    r.zero_sum = ($urandom_range(0, 99) < 6);
    return r;
  endfunction

  task automatic write_fix_enable(bit en);
    s_tvalid <= 1'b0;
    while (patch_expect_q.size() != 0) @(posedge clk);
    // Let the finish and result stages drain before the register changes.
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fix_en_model = en;
  endtask

  task automatic run_random_frames(int byte_goal, int frame_goal);
    int start_bytes;
    int start_frames;
    start_bytes  = bytes_sent;
    start_frames = frames_sent;
    while (bytes_sent - start_bytes < byte_goal || frames_sent - start_frames < frame_goal) begin
      if (frames_sent % 16 == 0) begin
        src_max_gap  = ($urandom_range(0, 3) == 0) ? 0 : 3;
        sink_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 3;
      end
      if ($urandom_range(0, 99) < 8) send_noise($urandom_range(1, 80), -1);
      else send_recipe(random_recipe());
    end
  endtask

  task automatic test_directed_frames();
    frame_recipe_t r;
    send_recipe(base_recipe(PROTO_TCP, 18));
    r = base_recipe(PROTO_TCP, 18);
    r.ihl = 4'd15;
    r.csum_mode = CS_INVERTED;
    send_recipe(r);
    send_recipe(base_recipe(PROTO_UDP, 8));
    r = base_recipe(PROTO_UDP, 21);
    r.zero_sum = 1'b1;
    send_recipe(r);
    r = base_recipe(PROTO_TCP, 31);
    r.zero_sum = 1'b1;
    r.csum_mode = CS_INVERTED;
    send_recipe(r);
    r = base_recipe(PROTO_UDP, 12);
    r.pad = 10;
    send_recipe(r);
    r = base_recipe(PROTO_TCP, 24);
    r.csum_mode = CS_WRONG;
    send_recipe(r);
    r = base_recipe(PROTO_UDP, 16);
    r.ether_type = 16'h86dd;
    send_recipe(r);
    r = base_recipe(PROTO_UDP, 16);
    r.version = 4'd6;
    send_recipe(r);
    r = base_recipe(PROTO_TCP, 30);
    r.ihl = 4'd4;
    send_recipe(r);
    r = base_recipe(PROTO_UDP, 30);
    r.ihl = 4'd0;
    send_recipe(r);
    r = base_recipe(PROTO_TCP, 20);
    r.cut = 1;
    send_recipe(r);
    r = base_recipe(PROTO_UDP, 10);
    r.tl_delta = 65535;
    send_recipe(r);
    r = base_recipe(PROTO_UDP, 10);
    r.tl_delta = -11;
    send_recipe(r);
    r = base_recipe(PROTO_UDP, 10);
    r.frag_lo = 8'h01;
    send_recipe(r);
    r = base_recipe(PROTO_TCP, 20);
    r.frag_hi = 8'h20;
    send_recipe(r);
    // Only the flag bits above the offset are set, so the frame still counts.
    r = base_recipe(PROTO_TCP, 20);
    r.frag_hi = 8'hc0;
    send_recipe(r);
    send_recipe(base_recipe(PROTO_ICMP, 20));
    send_recipe(base_recipe(PROTO_TCP, 17));
    send_recipe(base_recipe(PROTO_UDP, 7));
    r = base_recipe(PROTO_UDP, 8);
    r.cut = 9;
    send_recipe(r);
    send_noise(1, -1);
    send_noise(60, 8'hff);
    send_noise(60, 8'h00);
  endtask

  task automatic test_fix_disabled();
    write_fix_enable(1'b0);
    run_random_frames(150, 3);
    write_fix_enable(1'b1);
  endtask

  task automatic test_length_limit();
    src_max_gap  = 1;
    sink_max_gap = 3;
    // One byte more than the largest allowed frame.
    send_recipe(base_recipe(PROTO_TCP, MAX_FRAME_BYTES - 33));
  endtask

  task automatic test_random_traffic();
    run_random_frames(300, 4);
  endtask

  initial begin
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_fix_disabled();
    test_length_limit();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (patch_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("partial_l4_checksum_fixup: match");
    end else begin
      $display("partial_l4_checksum_fixup: mismatch");
    end
    $finish;
  end

  // Result side: random stalls, each verdict checked against the oldest
  // expectation.
  initial begin
    int            gap;
    patch_result_t got;
    patch_result_t exp;
    m_tready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, sink_max_gap);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = m_tdata;
      if (patch_expect_q.size() == 0) begin
        report_mismatch($sformatf("result with none expected: %h", m_tdata));
      end else begin
        exp = patch_expect_q.pop_front();
        if (got.patch !== exp.patch)
          report_mismatch($sformatf("patch_valid %b, expected %b", got.patch, exp.patch));
        if (got.offset !== exp.offset)
          report_mismatch($sformatf("checksum_offset %0d, expected %0d",
                                    got.offset, exp.offset));
        if (got.csum !== exp.csum)
          report_mismatch($sformatf("new_checksum %h, expected %h", got.csum, exp.csum));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("partial_l4_checksum_fixup: mismatch");
    $finish;
  end

endmodule
